// ----- rtl/grs_pkg.sv -----
// grs_pkg: shared types and constants for the group reverse stream block
// used by grs_ctrl, grs_datapath and group_reverse_stream; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package grs_pkg;

   // fixed field widths
   localparam int VALUE_W      = 32;
   localparam int GROUP_SIZE_W = 5;

   // group size after reset
   localparam logic [GROUP_SIZE_W-1:0] GROUP_SIZE_RESET = 5'd1;

   // controller states
   typedef enum logic {
      ST_FILL,
      ST_DRAIN
   } grs_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic accept;      // take the input word into the group memory
      logic load_group;  // the accepted word closes the group
      logic drain_en;    // read the held group back in reverse
   } grs_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic close_group; // the offered word would close the group
      logic last_issue;  // final memory read of the group this cycle
   } grs_status_type;

endpackage
`default_nettype wire

// ----- rtl/group_reverse_stream.sv -----
// group_reverse_stream: top level joining controller and datapath
// depends on grs_pkg, grs_ctrl and grs_datapath
// Input words are taken one per cycle while a group fills. The word that
// completes the group (group size reached, or end of list) closes it, and the
// input then stalls while the group is read back newest first through the
// single read port of the group memory, one word per cycle while the output
// does not stall. Reversed words pass through a read stage and an output
// register, so a stalled output does not lose words. The group size register
// is written through the csr port and is always ready; zero acts as one and
// values above MAX_GROUP saturate.
`timescale 1ns / 1ps
`default_nettype none
module group_reverse_stream #(
   parameter int MAX_GROUP = 16
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // input words
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire signed [grs_pkg::VALUE_W-1:0]   req_value,
   input  wire                                 req_end_of_list,
   // result words
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic signed [grs_pkg::VALUE_W-1:0]  rsp_value_res,
   output logic                                rsp_group_last,
   output logic                                rsp_list_last,
   // group size register write
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire [grs_pkg::GROUP_SIZE_W-1:0]     csr_group_size
);

   grs_pkg::grs_cmd_type    cmd;
   grs_pkg::grs_status_type status;
   logic                    csr_write;

   // register writes never wait
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // sequencer
   grs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // group memory and output pipeline
   grs_datapath #(
      .MAX_GROUP (MAX_GROUP)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_value       (req_value),
      .req_end_of_list (req_end_of_list),
      .csr_write       (csr_write),
      .csr_group_size  (csr_group_size),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value_res   (rsp_value_res),
      .rsp_group_last  (rsp_group_last),
      .rsp_list_last   (rsp_list_last)
   );

endmodule
`default_nettype wire

// ----- rtl/grs_ctrl.sv -----
// grs_ctrl: state machine sequencing group fill and reversed drain
// depends on grs_pkg; drives grs_datapath through command and status structs
`timescale 1ns / 1ps
`default_nettype none
module grs_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  grs_pkg::grs_status_type  status,
   output grs_pkg::grs_cmd_type     cmd
);

   grs_pkg::grs_state_type state_ff;
   grs_pkg::grs_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= grs_pkg::ST_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_stall      = 1'b1;
      case (state_ff)
         grs_pkg::ST_FILL: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid && status.close_group) begin
               cmd.load_group = 1'b1;
               state_in       = grs_pkg::ST_DRAIN;
            end
         end
         grs_pkg::ST_DRAIN: begin
            cmd.drain_en = 1'b1;
            if (status.last_issue) begin
               state_in = grs_pkg::ST_FILL;
            end
         end
         default: begin
            state_in = grs_pkg::ST_FILL;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- rtl/grs_datapath.sv -----
// grs_datapath: group memory, fill count, group size register, read-back pipeline
// depends on grs_pkg; commanded by grs_ctrl
`timescale 1ns / 1ps
`default_nettype none
module grs_datapath #(
   parameter int MAX_GROUP = 16
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  grs_pkg::grs_cmd_type                 cmd,
   output grs_pkg::grs_status_type              status,
   input  wire signed [grs_pkg::VALUE_W-1:0]    req_value,
   input  wire                                  req_end_of_list,
   input  wire                                  csr_write,
   input  wire [grs_pkg::GROUP_SIZE_W-1:0]      csr_group_size,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic signed [grs_pkg::VALUE_W-1:0]   rsp_value_res,
   output logic                                 rsp_group_last,
   output logic                                 rsp_list_last
);

   localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
   localparam int CNT_W = $clog2(MAX_GROUP + 1);
   localparam int CMP_W = ((CNT_W > grs_pkg::GROUP_SIZE_W) ? CNT_W
                                                           : grs_pkg::GROUP_SIZE_W) + 1;

   logic [grs_pkg::GROUP_SIZE_W-1:0]      group_size_ff;
   logic [CNT_W-1:0]                      fill_count_ff;
   logic [IDX_W-1:0]                      rd_ptr_ff;
   logic                                  eol_ff;
   logic signed [grs_pkg::VALUE_W-1:0]    group_mem [MAX_GROUP];

   logic                                  pf_valid_ff;
   logic signed [grs_pkg::VALUE_W-1:0]    pf_value_ff;
   logic                                  pf_group_last_ff;
   logic                                  pf_list_last_ff;

   logic                                  rsp_valid_ff;
   logic signed [grs_pkg::VALUE_W-1:0]    rsp_value_ff;
   logic                                  rsp_group_last_ff;
   logic                                  rsp_list_last_ff;

   logic [IDX_W-1:0]                      fill_idx;
   logic [CMP_W-1:0]                      size_ext;
   logic [CMP_W-1:0]                      k_eff;
   logic [CMP_W-1:0]                      count_next;
   logic                                  out_free;
   logic                                  issue;
   logic                                  ptr_zero;

   // group size register, loaded with the full width of the write
   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff <= grs_pkg::GROUP_SIZE_RESET;
      end else if (csr_write) begin
         group_size_ff <= csr_group_size;
      end
   end

   // effective group size: zero acts as one, saturate at the memory depth
   always_comb begin
      size_ext = CMP_W'(group_size_ff);
      if (group_size_ff == '0) begin
         k_eff = CMP_W'(1);
      end else if (size_ext > CMP_W'(MAX_GROUP)) begin
         k_eff = CMP_W'(MAX_GROUP);
      end else begin
         k_eff = size_ext;
      end
   end

   // close check for the word on offer
   assign fill_idx           = fill_count_ff[IDX_W-1:0];
   assign count_next         = CMP_W'(fill_count_ff) + CMP_W'(1);
   assign status.close_group = req_end_of_list || (count_next >= k_eff);

   // fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
      end else if (cmd.accept) begin
         if (cmd.load_group) begin
            fill_count_ff <= '0;
         end else begin
            fill_count_ff <= fill_count_ff + CNT_W'(1);
         end
      end
   end

   // group memory write port
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         group_mem[fill_idx] <= req_value;
      end
   end

   // read pointer and list end flag of the closed group
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
      end else if (cmd.load_group) begin
         rd_ptr_ff <= fill_idx;
      end else if (issue) begin
         rd_ptr_ff <= rd_ptr_ff - IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_group) begin
         eol_ff <= req_end_of_list;
      end
   end

   // read issue: next stage free or moving on
   assign out_free          = !rsp_valid_ff || !rsp_stall;
   assign issue             = cmd.drain_en && (!pf_valid_ff || out_free);
   assign ptr_zero          = (rd_ptr_ff == '0);
   assign status.last_issue = issue && ptr_zero;

   // registered memory read
   always_ff @(posedge clock) begin
      if (issue) begin
         pf_value_ff      <= group_mem[rd_ptr_ff];
         pf_group_last_ff <= ptr_zero;
         pf_list_last_ff  <= ptr_zero && eol_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pf_valid_ff <= 1'b0;
      end else if (issue) begin
         pf_valid_ff <= 1'b1;
      end else if (out_free) begin
         pf_valid_ff <= 1'b0;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= pf_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_value_ff      <= pf_value_ff;
         rsp_group_last_ff <= pf_group_last_ff;
         rsp_list_last_ff  <= pf_list_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value_res  = rsp_value_ff;
   assign rsp_group_last = rsp_group_last_ff;
   assign rsp_list_last  = rsp_list_last_ff;

`ifndef NO_ASSERTIONS
   // the fill count never reaches the memory depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(fill_count_ff) < CNT_W'(MAX_GROUP))
      else $error("fill count reached memory depth");

   // memory reads only while draining
   a_issue_drain: assert property (@(posedge clock) disable iff (reset)
      issue |-> cmd.drain_en)
      else $error("memory read outside drain");

   // a blocked read word holds in the read stage
   a_pf_hold: assert property (@(posedge clock) disable iff (reset)
      (pf_valid_ff && !out_free) |=> (pf_valid_ff && $stable(pf_value_ff)))
      else $error("read stage lost a word");

   // a list end word is always a group end word
   a_list_group: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_list_last_ff) |-> rsp_group_last_ff)
      else $error("list end without group end");
`endif

endmodule
`default_nettype wire

// ----- sim/group_reverse_stream_tb.sv -----
// group_reverse_stream_tb: self-checking bench for group_reverse_stream
// depends on grs_pkg and the group_reverse_stream rtl; needs nothing else
`timescale 1ns / 1ps
module group_reverse_stream_tb;

   localparam int GROUP_DEPTH   = 16;
   localparam int SETTLE_CYCLES = 24;
   localparam int MISMATCH_SHOWN = 10;

   typedef struct packed {
      logic signed [grs_pkg::VALUE_W-1:0] value;
      logic                               group_last;
      logic                               list_last;
   } reversed_word_type;

   // tracks the group being filled and the reversed words still owed
   class reverse_order_board;
      logic signed [grs_pkg::VALUE_W-1:0] held_words [GROUP_DEPTH];
      int unsigned                        held_count;
      logic [grs_pkg::GROUP_SIZE_W-1:0]   size_reg;
      reversed_word_type                  reversed_words [$];
      int unsigned                        words_in;
      int unsigned                        words_checked;
      int unsigned                        mismatches;
      int unsigned                        settings_seen;

      function new();
         held_count    = 0;
         size_reg      = grs_pkg::GROUP_SIZE_RESET;
         words_in      = 0;
         words_checked = 0;
         mismatches    = 0;
         settings_seen = 1;
      endfunction

      // zero acts as one, anything past the store depth saturates
      function int unsigned group_limit();
         if (size_reg == 0)
            return 1;
         if (size_reg > GROUP_DEPTH)
            return GROUP_DEPTH;
         return 32'(size_reg);
      endfunction

      function void set_group_size(logic [grs_pkg::GROUP_SIZE_W-1:0] code);
         size_reg = code;
         settings_seen++;
      endfunction

      function int unsigned pending();
         return reversed_words.size();
      endfunction

      // an accepted input word; a closing word releases the held group newest first
      function void take_word(logic signed [grs_pkg::VALUE_W-1:0] v, logic eol);
         reversed_word_type rw;
         words_in++;
         if (held_count < GROUP_DEPTH) begin
            held_words[held_count] = v;
            held_count++;
         end
         if (held_count < group_limit() && !eol)
            return;
         for (int i = held_count - 1; i >= 0; i--) begin
            rw.value      = held_words[i];
            rw.group_last = (i == 0);
            rw.list_last  = (i == 0) && eol;
            reversed_words.push_back(rw);
         end
         held_count = 0;
      endfunction

      function void note_mismatch(string what, reversed_word_type want,
                                  reversed_word_type got);
         mismatches++;
         if (mismatches <= MISMATCH_SHOWN)
            $display("%t: %s: expected value %h group_last %b list_last %b,",
                     $realtime, what, want.value, want.group_last, want.list_last,
                     " got value %h group_last %b list_last %b",
                     got.value, got.group_last, got.list_last);
      endfunction

      function void check_word(logic signed [grs_pkg::VALUE_W-1:0] v, logic gl, logic ll);
         reversed_word_type got;
         reversed_word_type want;
         got.value      = v;
         got.group_last = gl;
         got.list_last  = ll;
         if (reversed_words.size() == 0) begin
            want = '0;
            note_mismatch("word with nothing owed", want, got);
            return;
         end
         want = reversed_words.pop_front();
         words_checked++;
         if (got.value !== want.value || got.group_last !== want.group_last ||
             got.list_last !== want.list_last)
            note_mismatch("result word differs", want, got);
      endfunction

      // words still owed at the end count as failures
      function void close_out();
         if (reversed_words.size() != 0) begin
            mismatches += reversed_words.size();
            $display("%0d reversed words never arrived", reversed_words.size());
         end
      endfunction
   endclass

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_valid;
   logic                               req_stall;
   logic signed [grs_pkg::VALUE_W-1:0] req_value;
   logic                               req_end_of_list;
   logic                               rsp_valid;
   logic                               rsp_stall;
   logic signed [grs_pkg::VALUE_W-1:0] rsp_value_res;
   logic                               rsp_group_last;
   logic                               rsp_list_last;
   logic                               csr_valid;
   logic                               csr_ready;
   logic [grs_pkg::GROUP_SIZE_W-1:0]   csr_group_size;

   reverse_order_board board = new();
   bit                 pressure_on = 1'b0;
   bit                 pressure_done = 1'b0;

   group_reverse_stream #(
      .MAX_GROUP(GROUP_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_value(req_value),
      .req_end_of_list(req_end_of_list),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_value_res(rsp_value_res),
      .rsp_group_last(rsp_group_last),
      .rsp_list_last(rsp_list_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_group_size(csr_group_size)
   );

   always #1 clock = ~clock;

   // idling schedule: sender light / receiver heavy, then swapped, then none
   function automatic int unsigned idle_stage();
      if (board.words_in < 150)
         return 0;
      if (board.words_in < 280)
         return 1;
      return 2;
   endfunction

   function automatic int unsigned sender_gap_pct();
      case (idle_stage())
         0: return 28;
         1: return 85;
         default: return 0;
      endcase
   endfunction

   function automatic int unsigned receiver_stall_pct();
      case (idle_stage())
         0: return 85;
         1: return 28;
         default: return 0;
      endcase
   endfunction

   // mostly full random words, now and then an extreme
   function automatic logic signed [grs_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(11))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return '0;
         3: return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // offer one word and hold it until it is taken
   task automatic send_word(logic signed [grs_pkg::VALUE_W-1:0] v, logic eol);
      while (!pressure_on && sender_gap_pct() != 0 &&
             $urandom_range(99) < sender_gap_pct()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_value       <= v;
      req_end_of_list <= eol;
      do @(posedge clock); while (req_stall);
      board.take_word(v, eol);
   endtask

   // stop offering, let every owed word out, then give the block time to settle
   task automatic wait_settled();
      req_valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_group_size(logic [grs_pkg::GROUP_SIZE_W-1:0] code);
      csr_valid      <= 1'b1;
      csr_group_size <= code;
      do @(posedge clock); while (!csr_ready);
      board.set_group_size(code);
      csr_valid <= 1'b0;
   endtask

   // one random phase: a new group size, then whole lists, sometimes a dangling partial one
   task automatic run_phase(int unsigned phase_no);
      logic [grs_pkg::GROUP_SIZE_W-1:0] code;
      int unsigned                      limit;
      int unsigned                      budget;
      int unsigned                      sent;
      int unsigned                      len;
      case (phase_no)
         0: code = 5'd16;
         1: code = 5'd1;
         default:
            case ($urandom_range(9))
               0: code = 5'd0;
               1: code = grs_pkg::GROUP_SIZE_W'($urandom_range(17, 31));
               default: code = grs_pkg::GROUP_SIZE_W'($urandom_range(1, 16));
            endcase
      endcase
      wait_settled();
      write_group_size(code);
      limit  = board.group_limit();
      budget = $urandom_range(20, 45);
      sent   = 0;
      while (sent < budget) begin
         case ($urandom_range(3))
            0: len = limit * $urandom_range(1, 2);
            1: len = $urandom_range(1, limit);
            default: len = $urandom_range(1, 2 * limit + 3);
         endcase
         for (int i = 0; i < len; i++)
            send_word(pick_value(), i == len - 1);
         sent += len;
      end
      // leave a group half filled so the next size change lands mid-group
      if (limit > 1 && $urandom_range(2) == 0) begin
         len = $urandom_range(1, limit - 1);
         for (int i = 0; i < len; i++)
            send_word(pick_value(), 1'b0);
      end
   endtask

   // receiver: checks accepted words and stalls at random, with one long hold-off
   initial begin
      int unsigned hold_left;
      bit          random_stall;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            board.check_word(rsp_value_res, rsp_group_last, rsp_list_last);
         if (hold_left > 0) begin
            hold_left--;
         end else if (!pressure_done && board.words_in >= 300) begin
            pressure_done = 1'b1;
            hold_left     = 90;
         end
         pressure_on  = (hold_left > 0);
         random_stall = (receiver_stall_pct() != 0) &&
                        ($urandom_range(99) < receiver_stall_pct());
         rsp_stall <= (hold_left > 0) || random_stall;
      end
   end

   // stimulus
   initial begin
      int unsigned phase_no;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_value       <= '0;
      req_end_of_list <= 1'b0;
      csr_valid       <= 1'b0;
      csr_group_size  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: reset group size of one with the value extremes
      send_word(32'sh8000_0000, 1'b0);
      send_word(32'sh7fff_ffff, 1'b1);
      // zero group size behaves as one
      wait_settled();
      write_group_size(5'd0);
      send_word('0, 1'b0);
      send_word(-32'sd1, 1'b1);
      // oversize setting saturates; end flag lands on a full group
      wait_settled();
      write_group_size(5'd31);
      for (int i = 0; i < GROUP_DEPTH; i++)
         send_word(pick_value(), i == GROUP_DEPTH - 1);
      // shrink the group size while a group is part filled
      wait_settled();
      write_group_size(5'd4);
      for (int i = 0; i < 3; i++)
         send_word(pick_value(), 1'b0);
      wait_settled();
      write_group_size(5'd2);
      send_word(pick_value(), 1'b0);
      send_word(pick_value(), 1'b1);

      // random lists across many group sizes
      phase_no = 0;
      while (board.words_in < 355) begin
         run_phase(phase_no);
         phase_no++;
      end
      // close any dangling list so every held word comes out
      send_word(pick_value(), 1'b1);
      wait_settled();
      board.close_out();

      $display("Covered %0d input words over %0d group size settings,",
               board.words_in, board.settings_seen);
      $display("%0d reversed words checked", board.words_checked);
      if (board.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // watchdog
   initial begin
      #400000;
      $display("Timed out with %0d words still owed", board.pending());
      $display("Mismatches found");
      $finish;
   end

endmodule
